// File: design/assert_macros.svh
// Assertion macros shared by the ECG filter checker.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ECGF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ecgf check failed");

// Check that a condition in one cycle leads to another in the next cycle.
`define ECGF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecgf check failed");

`endif

// File: design/ecgf_pkg.sv
// Shared types, constants and the low-pass coefficient table of the ECG filter.
// No dependencies; used by the controller, datapath and interfaces.
package ecgf_pkg;

  // Widths of the channel fields
  localparam int STATUS_W   = 24;
  localparam int ECG_W      = 24;
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // FIR geometry: the newest input sits in a register, the rest in a ring buffer
  localparam int TAPS       = 161;
  localparam int HIST_DEPTH = TAPS - 1;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int TAP_W      = $clog2(TAPS + 1);
  localparam int COEFF_MID  = (TAPS - 1) / 2;
  localparam int ACC_W      = 32;

  // Lead-off flags are status bits 19..15
  localparam logic [STATUS_W-1:0] LEAD_OFF_MASK = 24'h0f8000;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET  = 16'd9;
  localparam logic [CFG_DATA_W-1:0] REFRACTORY_RESET = 16'd400;

  // DC scale by 0.992 = 124/125: t = d - ceil(d/125) toward zero.
  // ceil(a/125) = ((a + 124) * 67109) >> 23, exact for a below 2^18.
  localparam logic [16:0] DC_ROUND = 17'd124;
  localparam logic [16:0] DC_RECIP = 17'd67109;
  localparam int          DC_SHIFT = 23;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAT_THRESHOLD = 2'd0,
    CFG_REFRACTORY_MS  = 2'd1
  } cfg_index_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // capture the frame
    logic dc_scale;     // scale previous DC value by 0.992
    logic dc_update;    // finish DC removal, arm the MAC
    logic mac_run;      // step the tap pipeline
    logic fir_finish;   // saturate, shift, push history
    logic result_load;  // beat test and result register load
  } ecgf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lead_off;     // frame on the input port has a lead-off flag
    logic mac_done;     // all taps accumulated
  } ecgf_sts_t;

  // Symmetric 161-tap Q15 low-pass; fold the index onto the first half
  function automatic logic signed [SAMPLE_W-1:0] lp_coeff(input logic [TAP_W-1:0] k);
    logic [TAP_W-1:0] f;
    f = (k > TAP_W'(COEFF_MID)) ? (TAP_W'(TAPS - 1) - k) : k;
    case (f)
      0:  lp_coeff = -16'sd72;
      1:  lp_coeff = 16'sd122;
      2:  lp_coeff = -16'sd31;
      3:  lp_coeff = -16'sd99;
      4:  lp_coeff = 16'sd117;
      5:  lp_coeff = 16'sd0;
      6:  lp_coeff = -16'sd121;
      7:  lp_coeff = 16'sd105;
      8:  lp_coeff = 16'sd34;
      9:  lp_coeff = -16'sd137;
      10: lp_coeff = 16'sd84;
      11: lp_coeff = 16'sd70;
      12: lp_coeff = -16'sd146;
      13: lp_coeff = 16'sd55;
      14: lp_coeff = 16'sd104;
      15: lp_coeff = -16'sd147;
      16: lp_coeff = 16'sd20;
      17: lp_coeff = 16'sd135;
      18: lp_coeff = -16'sd137;
      19: lp_coeff = -16'sd21;
      20: lp_coeff = 16'sd160;
      21: lp_coeff = -16'sd117;
      22: lp_coeff = -16'sd64;
      23: lp_coeff = 16'sd177;
      24: lp_coeff = -16'sd87;
      25: lp_coeff = -16'sd108;
      26: lp_coeff = 16'sd185;
      27: lp_coeff = -16'sd48;
      28: lp_coeff = -16'sd151;
      29: lp_coeff = 16'sd181;
      30: lp_coeff = 16'sd0;
      31: lp_coeff = -16'sd188;
      32: lp_coeff = 16'sd164;
      33: lp_coeff = 16'sd54;
      34: lp_coeff = -16'sd218;
      35: lp_coeff = 16'sd134;
      36: lp_coeff = 16'sd112;
      37: lp_coeff = -16'sd238;
      38: lp_coeff = 16'sd90;
      39: lp_coeff = 16'sd171;
      40: lp_coeff = -16'sd244;
      41: lp_coeff = 16'sd33;
      42: lp_coeff = 16'sd229;
      43: lp_coeff = -16'sd235;
      44: lp_coeff = -16'sd36;
      45: lp_coeff = 16'sd280;
      46: lp_coeff = -16'sd208;
      47: lp_coeff = -16'sd115;
      48: lp_coeff = 16'sd322;
      49: lp_coeff = -16'sd161;
      50: lp_coeff = -16'sd203;
      51: lp_coeff = 16'sd350;
      52: lp_coeff = -16'sd92;
      53: lp_coeff = -16'sd296;
      54: lp_coeff = 16'sd361;
      55: lp_coeff = 16'sd0;
      56: lp_coeff = -16'sd391;
      57: lp_coeff = 16'sd348;
      58: lp_coeff = 16'sd117;
      59: lp_coeff = -16'sd486;
      60: lp_coeff = 16'sd305;
      61: lp_coeff = 16'sd264;
      62: lp_coeff = -16'sd577;
      63: lp_coeff = 16'sd225;
      64: lp_coeff = 16'sd445;
      65: lp_coeff = -16'sd660;
      66: lp_coeff = 16'sd93;
      67: lp_coeff = 16'sd676;
      68: lp_coeff = -16'sd733;
      69: lp_coeff = -16'sd119;
      70: lp_coeff = 16'sd991;
      71: lp_coeff = -16'sd793;
      72: lp_coeff = -16'sd480;
      73: lp_coeff = 16'sd1486;
      74: lp_coeff = -16'sd837;
      75: lp_coeff = -16'sd1226;
      76: lp_coeff = 16'sd2561;
      77: lp_coeff = -16'sd865;
      78: lp_coeff = -16'sd4018;
      79: lp_coeff = 16'sd9438;
      80: lp_coeff = 16'sd20972;
      default: lp_coeff = 16'sd0;
    endcase
  endfunction

endpackage

// File: design/ecgf_if.sv
// Valid/ready channel interfaces of the ECG filter: frames, results, register writes.
// Depends on ecgf_pkg for field widths.
interface ecgf_frame_if;
  logic                                 valid;
  logic                                 ready;
  logic [ecgf_pkg::STATUS_W-1:0]        status_word;
  logic signed [ecgf_pkg::ECG_W-1:0]    ecg_sample;
  logic [ecgf_pkg::TIME_W-1:0]          time_ms;

  modport source (output valid, status_word, ecg_sample, time_ms, input ready);
  modport sink   (input valid, status_word, ecg_sample, time_ms, output ready);
endinterface

interface ecgf_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ecgf_pkg::SAMPLE_W-1:0] filtered_sample;
  logic [ecgf_pkg::SAMPLE_W-1:0]        beat_interval_ms;
  logic                                 lead_off;

  modport source (output valid, filtered_sample, beat_interval_ms, lead_off, input ready);
  modport sink   (input valid, filtered_sample, beat_interval_ms, lead_off, output ready);
endinterface

interface ecgf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ecgf_pkg::CFG_IDX_W-1:0]       index;
  logic [ecgf_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ecg_filter_beat_detect_top.sv
// Top level of the ECG filter and beat detector.
// Depends on ecgf_pkg, the channel interfaces, ecgf_ctrl and ecgf_datapath.
//
// Usage:
//   frame  : one converter frame per request (status word, 24-bit sample, ms time).
//   result : one request per frame (filtered Q15 sample, last beat interval,
//            lead-off flag).
//   cfg    : register writes (0 beat threshold, 1 refractory ms); always ready,
//            write only while no frame is in flight. Other indexes are dropped.
// Sequencing:
//   A frame with a clean lead passes DC removal, then the low-pass FIR; the
//   161 taps of the low-pass FIR share one multiplier and one history memory
//   read port, one tap per cycle, then the tap pipeline drains.
//   A lead-off frame skips the filter and gives a zero result.
//   One frame is processed at a time; the next frame is accepted once the
//   previous result sits in the output register.
// Reset (synchronous, rst high): filter history reads as zero, DC state, beat
//   time and interval clear, registers return to threshold 9 and 400 ms.
// Stall: a result held by the receiver blocks only the next result; the
//   following frame is still accepted and computed, then waits.
module ecg_filter_beat_detect_top #(
  parameter int SLOPE_LAG = 3
) (
  input  logic          clk,
  input  logic          rst,
  ecgf_frame_if.sink    frame,
  ecgf_result_if.source result,
  ecgf_cfg_if.sink      cfg
);

  ecgf_pkg::ecgf_cmd_t cmd;
  ecgf_pkg::ecgf_sts_t sts;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  ecgf_ctrl u_ecgf_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  ecgf_datapath #(
    .SLOPE_LAG (SLOPE_LAG)
  ) u_ecgf_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .status_word      (frame.status_word),
    .ecg_sample       (frame.ecg_sample),
    .time_ms          (frame.time_ms),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .filtered_sample  (result.filtered_sample),
    .beat_interval_ms (result.beat_interval_ms),
    .lead_off         (result.lead_off)
  );

endmodule

// File: design/ecgf_datapath.sv
// Datapath of the ECG filter: DC removal, shared-multiplier FIR, beat detection.
// Depends on ecgf_pkg; driven by ecgf_ctrl through ecgf_cmd_t.
module ecgf_datapath #(
  parameter int SLOPE_LAG = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ecgf_pkg::ecgf_cmd_t                  cmd,
  output ecgf_pkg::ecgf_sts_t                  sts,
  input  logic [ecgf_pkg::STATUS_W-1:0]        status_word,
  input  logic signed [ecgf_pkg::ECG_W-1:0]    ecg_sample,
  input  logic [ecgf_pkg::TIME_W-1:0]          time_ms,
  input  logic                                 cfg_we,
  input  logic [ecgf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecgf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [ecgf_pkg::SAMPLE_W-1:0] filtered_sample,
  output logic [ecgf_pkg::SAMPLE_W-1:0]        beat_interval_ms,
  output logic                                 lead_off
);

  localparam int SW = ecgf_pkg::SAMPLE_W;
  localparam int AW = ecgf_pkg::HIST_AW;
  localparam int TW = ecgf_pkg::TAP_W;
  localparam int CW = ecgf_pkg::ACC_W;

  // Configuration registers
  logic [ecgf_pkg::CFG_DATA_W-1:0] thr;
  logic [ecgf_pkg::CFG_DATA_W-1:0] refr;

  // Frame capture
  logic                            frame_off;
  logic signed [SW-1:0]            x_cur;
  logic [ecgf_pkg::TIME_W-1:0]     time_cur;

  // DC removal state
  logic signed [SW-1:0]            prev_x;
  logic signed [SW-1:0]            prev_dc;
  logic signed [SW-1:0]            t_scaled;
  logic signed [SW-1:0]            fir_in;
  logic [16:0]                     dc_mag;
  logic [16:0]                     dc_num;
  logic [33:0]                     dc_prod;
  logic signed [SW-1:0]            dc_quo;
  logic signed [SW-1:0]            dc_t;
  logic signed [SW-1:0]            dc_new;

  // FIR history ring and tap pipeline
  logic signed [SW-1:0]            hist_mem [ecgf_pkg::HIST_DEPTH];
  logic [AW-1:0]                   wptr;
  logic [AW-1:0]                   rptr;
  logic [TW-1:0]                   fill;
  logic [TW-1:0]                   tap;
  logic                            a_vld;
  logic [TW-1:0]                   a_tap;
  logic signed [SW-1:0]            rd_data;
  logic                            b_vld;
  logic signed [CW-1:0]            prod;
  logic signed [CW-1:0]            acc;
  logic signed [SW-1:0]            mac_opnd;
  logic signed [CW-1:0]            mac_prod;
  logic signed [SW-1:0]            y_sat;
  logic signed [SW-1:0]            y;

  // Beat detection
  logic signed [SW-1:0]            recent [SLOPE_LAG];
  logic [ecgf_pkg::TIME_W-1:0]     last_time;
  logic [SW-1:0]                   interval;
  logic signed [SW+1:0]            slope;
  logic signed [SW+1:0]            thr_ext;
  logic [ecgf_pkg::TIME_W-1:0]     elapsed;
  logic                            beat_hit;
  logic [SW-1:0]                   interval_next;

  // Status back to the controller
  assign sts.lead_off = |(status_word & ecgf_pkg::LEAD_OFF_MASK);
  assign sts.mac_done = (tap == TW'(ecgf_pkg::TAPS)) && !a_vld && !b_vld;

  // Scale the previous DC value by 124/125, truncating toward zero
  always_comb begin
    dc_mag  = prev_dc[SW-1] ? (17'd0 - {prev_dc[SW-1], prev_dc}) : {1'b0, prev_dc};
    dc_num  = dc_mag + ecgf_pkg::DC_ROUND;
    dc_prod = 34'(dc_num) * 34'(ecgf_pkg::DC_RECIP);
    dc_quo  = SW'(dc_prod[33:ecgf_pkg::DC_SHIFT]);
    dc_t    = prev_dc[SW-1] ? (prev_dc + dc_quo) : (prev_dc - dc_quo);
    dc_new  = x_cur - prev_x + t_scaled;
  end

  // Select the tap operand: newest input, stored history, or zero before fill
  always_comb begin
    if (a_tap == '0) begin
      mac_opnd = fir_in;
    end else if (a_tap <= fill) begin
      mac_opnd = rd_data;
    end else begin
      mac_opnd = '0;
    end
    mac_prod = CW'(ecgf_pkg::lp_coeff(a_tap)) * CW'(mac_opnd);
  end

  // Saturate to [-2^30, 2^30-1] and drop 15 fraction bits
  always_comb begin
    case (acc[CW-1:CW-2])
      2'b01:   y_sat = {1'b0, {(SW-1){1'b1}}};
      2'b10:   y_sat = {1'b1, {(SW-1){1'b0}}};
      default: y_sat = acc[CW-2:CW-2-SW+1];
    endcase
  end

  // Slope over SLOPE_LAG outputs and refractory check
  always_comb begin
    slope         = (SW+2)'(y) - (SW+2)'(recent[SLOPE_LAG-1]);
    thr_ext       = signed'({2'b00, thr});
    elapsed       = time_cur - last_time;
    beat_hit      = (slope > thr_ext) && (elapsed > {16'd0, refr});
    interval_next = beat_hit ? elapsed[SW-1:0] : interval;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= ecgf_pkg::THRESHOLD_RESET;
      refr <= ecgf_pkg::REFRACTORY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ecgf_pkg::CFG_BEAT_THRESHOLD: thr  <= cfg_data;
        ecgf_pkg::CFG_REFRACTORY_MS:  refr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter and detector state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_dc   <= '0;
      wptr      <= '0;
      fill      <= '0;
      tap       <= TW'(ecgf_pkg::TAPS);
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      last_time <= '0;
      interval  <= '0;
      for (int i = 0; i < SLOPE_LAG; i++) recent[i] <= '0;
    end else begin
      // Close DC removal and arm the tap sequence
      if (cmd.dc_update) begin
        prev_dc <= dc_new;
        prev_x  <= x_cur;
        tap     <= '0;
        a_vld   <= 1'b0;
        b_vld   <= 1'b0;
      end
      // Advance the tap pipeline: issue, multiply, accumulate
      if (cmd.mac_run) begin
        if (tap < TW'(ecgf_pkg::TAPS)) begin
          a_vld <= 1'b1;
          tap   <= tap + 1'b1;
        end else begin
          a_vld <= 1'b0;
        end
        b_vld <= a_vld;
      end
      // Push the new FIR input into the ring
      if (cmd.fir_finish) begin
        wptr <= (wptr == AW'(ecgf_pkg::HIST_DEPTH - 1)) ? '0 : wptr + 1'b1;
        if (fill != TW'(ecgf_pkg::HIST_DEPTH)) fill <= fill + 1'b1;
      end
      // Shift the output history and record an accepted beat
      if (cmd.result_load) begin
        recent[0] <= y;
        for (int i = 1; i < SLOPE_LAG; i++) recent[i] <= recent[i-1];
        interval <= interval_next;
        if (beat_hit) last_time <= time_cur;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_off <= sts.lead_off;
      x_cur     <= ecg_sample[ecgf_pkg::ECG_W-1 -: SW];
      time_cur  <= time_ms;
      if (sts.lead_off) y <= '0;
    end
    if (cmd.dc_scale) t_scaled <= dc_t;
    if (cmd.dc_update) begin
      fir_in <= dc_new >>> 2;
      acc    <= '0;
      rptr   <= (wptr == '0) ? AW'(ecgf_pkg::HIST_DEPTH - 1) : wptr - 1'b1;
    end
    if (cmd.mac_run) begin
      if (tap < TW'(ecgf_pkg::TAPS)) begin
        a_tap <= tap;
        if (tap != '0) begin
          rptr <= (rptr == '0) ? AW'(ecgf_pkg::HIST_DEPTH - 1) : rptr - 1'b1;
        end
      end
      if (a_vld) prod <= mac_prod;
      if (b_vld) acc <= acc + prod;
    end
    if (cmd.fir_finish) y <= y_sat;
    if (cmd.result_load) begin
      filtered_sample  <= y;
      beat_interval_ms <= interval_next;
      lead_off         <= frame_off;
    end
  end

  // History memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.fir_finish) hist_mem[wptr] <= fir_in;
    rd_data <= hist_mem[rptr];
  end

endmodule

// File: design/ecgf_ctrl.sv
// Sequencing controller of the ECG filter: frame handshake, phases, result register.
// Depends on ecgf_pkg for the command and status structs.
module ecgf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output ecgf_pkg::ecgf_cmd_t cmd,
  input  ecgf_pkg::ecgf_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_DC,
    S_MAC,
    S_FIR,
    S_BEAT
  } state_t;

  state_t state;
  state_t state_next;

  // Take a frame only between items
  assign frame_ready = (state == S_IDLE);

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Decode phase commands and advance
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (frame_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.lead_off ? S_BEAT : S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.dc_scale = 1'b1;
        state_next   = S_DC;
      end
      S_DC: begin
        cmd.dc_update = 1'b1;
        state_next    = S_MAC;
      end
      S_MAC: begin
        cmd.mac_run = 1'b1;
        if (sts.mac_done) state_next = S_FIR;
      end
      S_FIR: begin
        cmd.fir_finish = 1'b1;
        state_next     = S_BEAT;
      end
      S_BEAT: begin
        // Wait for the result register to drain
        if (!result_valid || result_ready) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: design/ecgf_checker.sv
// Port-level checks of the ECG filter, bound to the top level.
// Depends on assert_macros.svh and ecgf_pkg.
`include "assert_macros.svh"

module ecgf_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 frame_valid,
  input logic                                 frame_ready,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic signed [ecgf_pkg::SAMPLE_W-1:0] filtered_sample,
  input logic [ecgf_pkg::SAMPLE_W-1:0]        beat_interval_ms,
  input logic                                 lead_off
);

  logic       frame_acc;
  logic       result_acc;
  logic [1:0] pending;

  assign frame_acc  = frame_valid && frame_ready;
  assign result_acc = result_valid && result_ready;

  // Count frames accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, frame_acc} - {1'b0, result_acc};
    end
  end

  `ECGF_ASSERT_NEXT(a_busy_after_accept, clk, rst, frame_acc, !frame_ready)
  `ECGF_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(filtered_sample) && $stable(beat_interval_ms) && $stable(lead_off))
  `ECGF_ASSERT(a_no_extra_result, clk, rst, result_acc |-> (pending != 2'd0))
  `ECGF_ASSERT(a_two_pending_blocks, clk, rst, (pending == 2'd2) |-> !frame_ready)
  `ECGF_ASSERT(a_lead_off_zero, clk, rst, (result_valid && lead_off) |-> (filtered_sample == 16'sd0))

endmodule

bind ecg_filter_beat_detect_top ecgf_checker u_ecgf_checker (
  .clk              (clk),
  .rst              (rst),
  .frame_valid      (frame.valid),
  .frame_ready      (frame.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .filtered_sample  (result.filtered_sample),
  .beat_interval_ms (result.beat_interval_ms),
  .lead_off         (result.lead_off)
);
